// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // operation codes carried on the request channel
  localparam logic [2:0] OP_REG   = 3'd0;
  localparam logic [2:0] OP_EXEC  = 3'd1;
  localparam logic [2:0] OP_HALT  = 3'd2;
  localparam logic [2:0] OP_CHG   = 3'd3;
  localparam logic [2:0] OP_RUN   = 3'd4;
  localparam logic [2:0] OP_CLR   = 3'd5;
  localparam logic [2:0] OP_QUERY = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // mode flag bit positions
  localparam int unsigned MODE_NOW  = 0;
  localparam int unsigned MODE_HALT = 1;
  localparam int unsigned MODE_SKIP = 2;

  // one quotient bit per divider step, 64-bit dividend
  localparam int unsigned DIV_STEPS = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG,
    S_SET,
    S_RUN,
    S_EX_CHK,
    S_DIV,
    S_EX_BASE,
    S_EX_ADD,
    S_Q_SCAN,
    S_Q_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        sub;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        cy;
    logic [63:0] val;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/pts_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared 64-bit add/subtract unit; cy is carry on add, borrow on subtract.
module pts_alu (
  input  pts_pkg::alu_req_t req,
  output pts_pkg::alu_res_t res
);

  logic [64:0] sum;

  assign sum = req.sub ? ({1'b0, req.a} - {1'b0, req.b})
                       : ({1'b0, req.a} + {1'b0, req.b});

  assign res.cy  = sum[64];
  assign res.val = sum[63:0];

endmodule

`default_nettype wire

// ===== rtl/periodic_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Periodic task scheduler table.
// Request channel (in_*): one operation plus the current time in ms. in_ready is
// high while the sequencer is idle; a request is taken when in_valid and in_ready
// are both high. Result channel (out_*): one result per request, or one per
// registered task for execute on a non-empty table, in slot order, with out_last on the final one.
// Config channel (cfg_*): always ready, writes max_period; write it only while idle.
// Datapath: every cycle does at most one 64-bit add or subtract in the shared unit.
// A valid register, change, halt, run or clear passes one update state (S_REG, S_SET
// or S_RUN) before S_EMIT; query scans each registered slot in S_Q_SCAN, then S_Q_WAIT.
// Execute checks each task in S_EX_CHK; a due task also runs the 64-step restoring divider
// that finds the missed runs and the catch-up remainder (one quotient bit per cycle).
// A finished result sits in the output register, so the sequencer goes back to idle
// and takes the next request while the receiver stalls; it only waits when it has
// a new result to place and the previous one is still untaken.
// Reset empties the table (task count zero), restores max_period to all ones and
// drops out_valid. No clearing pass: only slots below the count are ever read.
module periodic_task_scheduler #(
  parameter int unsigned TASKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [3:0]  in_task_sel,
  input  wire logic [31:0] in_period_ms,
  input  wire logic [2:0]  in_mode_flags,
  input  wire logic [63:0] in_now_ms,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_task_id,
  output logic [1:0]       out_status,
  output logic [7:0]       out_fire_count,
  output logic [31:0]      out_wait_ms,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CW = $clog2(TASKS + 1);

  pts_pkg::state_t state_r, state_nxt;

  logic [2:0]    op_r, op_nxt;
  logic [3:0]    sel_r, sel_nxt;
  logic [31:0]   per_r, per_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [63:0]   now_r, now_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   max_period_r;

  // task table
  logic [31:0] per_tbl  [TASKS];
  logic [63:0] dl_tbl   [TASKS];
  logic        halt_tbl [TASKS];
  logic        skip_tbl [TASKS];

  logic        wr_per, wr_dl, wr_halt, wr_skip;
  logic [31:0] wr_per_d;
  logic [63:0] wr_dl_d;
  logic        wr_halt_d, wr_skip_d;

  logic [31:0] rd_per;
  logic [63:0] rd_dl;
  logic        rd_halt, rd_skip;

  // divider and scan working registers
  logic [63:0]   q_r, q_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [5:0]    div_cnt_r, div_cnt_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [63:0]   best_r, best_nxt;
  logic [IW-1:0] best_id_r, best_id_nxt;
  logic          found_r, found_nxt;

  // result waiting to go into the output register
  logic [3:0]  pend_id_r, pend_id_nxt;
  logic [1:0]  pend_st_r, pend_st_nxt;
  logic [7:0]  pend_fire_r, pend_fire_nxt;
  logic [31:0] pend_wait_r, pend_wait_nxt;
  logic        pend_last_r, pend_last_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [3:0]  out_id_r;
  logic [1:0]  out_st_r;
  logic [7:0]  out_fire_r;
  logic [31:0] out_wait_r;
  logic        out_last_r;

  pts_pkg::alu_req_t alu_req;
  pts_pkg::alu_res_t alu_res;

  logic          slot_ok;
  logic          idx_is_last;
  logic [32:0]   trial;
  logic [63:0]   sat_sum;

  pts_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  assign rd_per  = per_tbl[idx_r];
  assign rd_dl   = dl_tbl[idx_r];
  assign rd_halt = halt_tbl[idx_r];
  assign rd_skip = skip_tbl[idx_r];

  assign slot_ok     = {1'b0, in_task_sel} < 5'(cnt_r);
  assign idx_is_last = (CW'(idx_r) + CW'(1)) == cnt_r;
  assign trial       = {rem_r, q_r[63]};
  assign sat_sum     = alu_res.cy ? '1 : alu_res.val;

  assign in_ready  = (state_r == pts_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_task_id    = out_id_r;
  assign out_status     = out_st_r;
  assign out_fire_count = out_fire_r;
  assign out_wait_ms    = out_wait_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pts_pkg::S_IDLE;
      cnt_r        <= '0;
      max_period_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        max_period_r <= cfg_data;
      end
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sel_r       <= sel_nxt;
    per_r       <= per_nxt;
    mode_r      <= mode_nxt;
    now_r       <= now_nxt;
    idx_r       <= idx_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    base_r      <= base_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    found_r     <= found_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_st_r   <= pend_st_nxt;
    pend_fire_r <= pend_fire_nxt;
    pend_wait_r <= pend_wait_nxt;
    pend_last_r <= pend_last_nxt;
    if (out_load) begin
      out_id_r   <= pend_id_r;
      out_st_r   <= pend_st_r;
      out_fire_r <= pend_fire_r;
      out_wait_r <= pend_wait_r;
      out_last_r <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_per) begin
      per_tbl[idx_r] <= wr_per_d;
    end
    if (wr_dl) begin
      dl_tbl[idx_r] <= wr_dl_d;
    end
    if (wr_halt) begin
      halt_tbl[idx_r] <= wr_halt_d;
    end
    if (wr_skip) begin
      skip_tbl[idx_r] <= wr_skip_d;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    per_nxt       = per_r;
    mode_nxt      = mode_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    base_nxt      = base_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    found_nxt     = found_r;
    pend_id_nxt   = pend_id_r;
    pend_st_nxt   = pend_st_r;
    pend_fire_nxt = pend_fire_r;
    pend_wait_nxt = pend_wait_r;
    pend_last_nxt = pend_last_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_per        = 1'b0;
    wr_dl         = 1'b0;
    wr_halt       = 1'b0;
    wr_skip       = 1'b0;
    wr_per_d      = per_r;
    wr_dl_d       = sat_sum;
    wr_halt_d     = 1'b0;
    wr_skip_d     = 1'b0;
    alu_req.sub   = 1'b0;
    alu_req.a     = now_r;
    alu_req.b     = {32'b0, per_r};

    case (state_r)
      pts_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          sel_nxt       = in_task_sel;
          per_nxt       = in_period_ms;
          mode_nxt      = in_mode_flags;
          now_nxt       = in_now_ms;
          pend_id_nxt   = '0;
          pend_st_nxt   = pts_pkg::ST_ERR;
          pend_fire_nxt = '0;
          pend_wait_nxt = '0;
          pend_last_nxt = 1'b1;
          state_nxt     = pts_pkg::S_EMIT;
          case (in_op)
            pts_pkg::OP_REG: begin
              if (in_period_ms != '0 && in_period_ms <= max_period_r &&
                  cnt_r < CW'(TASKS)) begin
                idx_nxt   = IW'(cnt_r);
                state_nxt = pts_pkg::S_REG;
              end
            end
            pts_pkg::OP_EXEC: begin
              if (cnt_r == '0) begin
                pend_st_nxt = pts_pkg::ST_NONE;
              end else begin
                idx_nxt   = '0;
                state_nxt = pts_pkg::S_EX_CHK;
              end
            end
            pts_pkg::OP_HALT, pts_pkg::OP_CHG: begin
              pend_id_nxt = in_task_sel;
              if (slot_ok) begin
                idx_nxt   = IW'(in_task_sel);
                state_nxt = pts_pkg::S_SET;
              end
            end
            pts_pkg::OP_RUN, pts_pkg::OP_CLR: begin
              pend_id_nxt = in_task_sel;
              if (slot_ok) begin
                idx_nxt   = IW'(in_task_sel);
                state_nxt = pts_pkg::S_RUN;
              end
            end
            pts_pkg::OP_QUERY: begin
              if (cnt_r == '0) begin
                pend_st_nxt   = pts_pkg::ST_NONE;
                pend_wait_nxt = '1;
              end else begin
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = pts_pkg::S_Q_SCAN;
              end
            end
            default: begin
              // unknown op: error result, already set up
            end
          endcase
        end
      end

      pts_pkg::S_REG: begin
        // first deadline: now, or now plus period saturated
        wr_per    = 1'b1;
        wr_dl     = 1'b1;
        wr_dl_d   = mode_r[pts_pkg::MODE_NOW] ? now_r : sat_sum;
        wr_halt   = 1'b1;
        wr_halt_d = mode_r[pts_pkg::MODE_HALT];
        wr_skip   = 1'b1;
        wr_skip_d = mode_r[pts_pkg::MODE_SKIP];
        cnt_nxt   = cnt_r + CW'(1);
        pend_id_nxt = 4'(idx_r);
        pend_st_nxt = pts_pkg::ST_OK;
        state_nxt   = pts_pkg::S_EMIT;
      end

      pts_pkg::S_SET: begin
        pend_st_nxt = pts_pkg::ST_OK;
        if (op_r == pts_pkg::OP_HALT) begin
          wr_halt   = 1'b1;
          wr_halt_d = 1'b1;
        end else if (!rd_halt || per_r > max_period_r) begin
          pend_st_nxt = pts_pkg::ST_ERR;
        end else begin
          // zero keeps the old period
          wr_per = (per_r != '0);
        end
        state_nxt = pts_pkg::S_EMIT;
      end

      pts_pkg::S_RUN: begin
        alu_req.b = {32'b0, rd_per};
        wr_dl     = 1'b1;
        if (op_r == pts_pkg::OP_RUN) begin
          wr_halt   = 1'b1;
          wr_halt_d = 1'b0;
        end
        pend_st_nxt = pts_pkg::ST_OK;
        state_nxt   = pts_pkg::S_EMIT;
      end

      pts_pkg::S_EX_CHK: begin
        // now - deadline; a borrow means the task is not due yet
        alu_req.sub   = 1'b1;
        alu_req.b     = rd_dl;
        pend_id_nxt   = 4'(idx_r);
        pend_st_nxt   = pts_pkg::ST_OK;
        pend_wait_nxt = '0;
        pend_last_nxt = idx_is_last;
        pend_fire_nxt = '0;
        state_nxt     = pts_pkg::S_EMIT;
        if (!alu_res.cy) begin
          if (rd_per == '0) begin
            pend_fire_nxt = rd_halt ? 8'd0 : 8'd1;
          end else begin
            q_nxt       = alu_res.val;
            rem_nxt     = '0;
            div_cnt_nxt = '0;
            state_nxt   = pts_pkg::S_DIV;
          end
        end
      end

      pts_pkg::S_DIV: begin
        // restoring step: shift in the next dividend bit, try to subtract period
        alu_req.sub = 1'b1;
        alu_req.a   = {31'b0, trial};
        alu_req.b   = {32'b0, rd_per};
        if (!alu_res.cy) begin
          rem_nxt = alu_res.val[31:0];
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'(pts_pkg::DIV_STEPS - 1)) begin
          state_nxt = pts_pkg::S_EX_BASE;
        end
      end

      pts_pkg::S_EX_BASE: begin
        // last deadline reached: now minus remainder, no wrap possible
        alu_req.sub = 1'b1;
        alu_req.b   = {32'b0, rem_r};
        base_nxt    = alu_res.val;
        state_nxt   = pts_pkg::S_EX_ADD;
      end

      pts_pkg::S_EX_ADD: begin
        alu_req.a = base_r;
        alu_req.b = {32'b0, rd_per};
        wr_dl     = 1'b1;
        if (rd_halt) begin
          pend_fire_nxt = '0;
        end else if (rd_skip) begin
          pend_fire_nxt = 8'd1;
        end else if (q_r >= 64'd255) begin
          pend_fire_nxt = 8'd255;
        end else begin
          pend_fire_nxt = q_r[7:0] + 8'd1;
        end
        state_nxt = pts_pkg::S_EMIT;
      end

      pts_pkg::S_Q_SCAN: begin
        // deadline - best; a borrow means this one is earlier
        alu_req.sub = 1'b1;
        alu_req.a   = rd_dl;
        alu_req.b   = best_r;
        if (!rd_halt && (!found_r || alu_res.cy)) begin
          found_nxt   = 1'b1;
          best_nxt    = rd_dl;
          best_id_nxt = idx_r;
        end
        if (idx_is_last) begin
          state_nxt = pts_pkg::S_Q_WAIT;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      pts_pkg::S_Q_WAIT: begin
        alu_req.sub   = 1'b1;
        alu_req.a     = best_r;
        alu_req.b     = now_r;
        pend_last_nxt = 1'b1;
        pend_fire_nxt = '0;
        if (!found_r) begin
          pend_id_nxt   = '0;
          pend_st_nxt   = pts_pkg::ST_NONE;
          pend_wait_nxt = '1;
        end else begin
          pend_id_nxt = 4'(best_id_r);
          pend_st_nxt = pts_pkg::ST_OK;
          if (alu_res.cy) begin
            pend_wait_nxt = '0;
          end else if (alu_res.val[63:32] != '0) begin
            pend_wait_nxt = '1;
          end else begin
            pend_wait_nxt = alu_res.val[31:0];
          end
        end
        state_nxt = pts_pkg::S_EMIT;
      end

      pts_pkg::S_EMIT: begin
        // hold until the output register is free, then advance
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (op_r == pts_pkg::OP_EXEC && !pend_last_r) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = pts_pkg::S_EX_CHK;
          end else begin
            state_nxt = pts_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = pts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_task_id,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_fire_count,
  input wire logic [31:0] out_wait_ms,
  input wire logic        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_task_id) &&
    $stable(out_status) && $stable(out_fire_count) && $stable(out_wait_ms) &&
    $stable(out_last))
    else $error("stalled result changed");

  // errors and no-task answers never report runs
  a_err_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pts_pkg::ST_OK |-> out_fire_count == 8'd0)
    else $error("run count on a non-ok result");

  // a no-task answer (empty table, or no running task on query) is always the only result of its request
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pts_pkg::ST_NONE |-> out_last)
    else $error("no-tasks result not last");

  // wait time comes only from query, which never reports runs
  a_wait_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_ms != 32'd0 |-> out_fire_count == 8'd0 && out_last)
    else $error("wait time on an execute result");

  // reset drops the result channel
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_task_id(out_task_id),
  .out_status(out_status),
  .out_fire_count(out_fire_count),
  .out_wait_ms(out_wait_ms),
  .out_last(out_last)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TASKS = 8;
  // op code 7 has no meaning in the block and must answer with an error
  localparam logic [2:0] OP_UNKNOWN = 3'd7;
  // longest run of cycles with no request, result or config write taken
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // quiet cycles before a config write and before the final verdict
  localparam int unsigned CFG_GAP = 20;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  task_sel;
    logic [31:0] period_ms;
    logic [2:0]  mode_flags;
    logic [63:0] now_ms;
  } sched_req_t;

  typedef struct packed {
    logic [3:0]  task_id;
    logic [1:0]  status;
    logic [7:0]  fire_count;
    logic [31:0] wait_ms;
    logic        last;
  } sched_res_t;

  // every block input holds a known value from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [3:0]  in_task_sel = '0;
  logic [31:0] in_period_ms = '0;
  logic [2:0]  in_mode_flags = '0;
  logic [63:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_task_id;
  logic [1:0]  out_status;
  logic [7:0]  out_fire_count;
  logic [31:0] out_wait_ms;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // mirror of the task table, advanced on every request the block takes
  logic [31:0] mirror_max_period;
  int unsigned mirror_count;
  logic [31:0] mirror_period[TASKS];
  logic [63:0] mirror_deadline[TASKS];
  bit          mirror_halted[TASKS];
  bit          mirror_skip[TASKS];

  sched_req_t  request_queue[$];   // requests waiting for the driver
  sched_res_t  awaited_results[$]; // predicted results, oldest first
  sched_req_t  shown_req;          // request currently on the in_ pins

  // generator's view: slots it expects to be filled, and a running clock
  int unsigned planned_count;
  logic [63:0] wall_ms;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  periodic_task_scheduler #(
    .TASKS(TASKS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_task_sel   (in_task_sel),
    .in_period_ms  (in_period_ms),
    .in_mode_flags (in_mode_flags),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_task_id   (out_task_id),
    .out_status    (out_status),
    .out_fire_count(out_fire_count),
    .out_wait_ms   (out_wait_ms),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // 64-bit add that sticks at all ones instead of wrapping
  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? '1 : sum[63:0];
  endfunction

  // Apply one accepted request to the table mirror and queue the results it
  // should produce, in slot order for execute.
  function automatic void schedule_step(sched_req_t r);
    sched_res_t  res;
    bit          slot_ok;
    bit          found;
    logic [63:0] gap;
    logic [63:0] quot;
    logic [63:0] runs;
    logic [63:0] step;
    logic [63:0] best;
    logic [3:0]  best_id;
    res = '0;
    res.last = 1'b1;
    slot_ok = r.task_sel < mirror_count;
    case (r.op)
      pts_pkg::OP_REG: begin
        if (r.period_ms == 0 || r.period_ms > mirror_max_period ||
            mirror_count >= TASKS) begin
          res.status = pts_pkg::ST_ERR;
        end else begin
          mirror_period[mirror_count] = r.period_ms;
          mirror_deadline[mirror_count] = r.mode_flags[pts_pkg::MODE_NOW] ? r.now_ms :
              clamp_add(r.now_ms, {32'b0, r.period_ms});
          mirror_halted[mirror_count] = r.mode_flags[pts_pkg::MODE_HALT];
          mirror_skip[mirror_count] = r.mode_flags[pts_pkg::MODE_SKIP];
          res.task_id = 4'(mirror_count);
          mirror_count++;
        end
        awaited_results.push_back(res);
      end
      pts_pkg::OP_EXEC: begin
        if (mirror_count == 0) begin
          res.status = pts_pkg::ST_NONE;
          awaited_results.push_back(res);
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            runs = 0;
            step = {32'b0, mirror_period[i]};
            if (mirror_deadline[i] <= r.now_ms) begin
              if (step == 0) begin
                runs = 1;
              end else begin
                // catch up: count the missed runs, land on the next one past now
                gap = r.now_ms - mirror_deadline[i];
                quot = gap / step;
                runs = quot + 1;
                mirror_deadline[i] = clamp_add(mirror_deadline[i] + quot * step, step);
              end
            end
            if (mirror_halted[i]) begin
              runs = 0;
            end else if (mirror_skip[i] && runs > 1) begin
              runs = 1;
            end
            res = '0;
            res.task_id = 4'(i);
            res.status = pts_pkg::ST_OK;
            res.fire_count = (runs > 255) ? 8'd255 : runs[7:0];
            res.last = (i + 1 == mirror_count);
            awaited_results.push_back(res);
          end
        end
      end
      pts_pkg::OP_HALT: begin
        res.task_id = r.task_sel;
        if (!slot_ok) begin
          res.status = pts_pkg::ST_ERR;
        end else begin
          mirror_halted[r.task_sel] = 1'b1;
        end
        awaited_results.push_back(res);
      end
      pts_pkg::OP_CHG: begin
        res.task_id = r.task_sel;
        if (!slot_ok || !mirror_halted[r.task_sel] || r.period_ms > mirror_max_period) begin
          res.status = pts_pkg::ST_ERR;
        end else if (r.period_ms != 0) begin
          mirror_period[r.task_sel] = r.period_ms;
        end
        awaited_results.push_back(res);
      end
      pts_pkg::OP_RUN, pts_pkg::OP_CLR: begin
        res.task_id = r.task_sel;
        if (!slot_ok) begin
          res.status = pts_pkg::ST_ERR;
        end else begin
          if (r.op == pts_pkg::OP_RUN) begin
            mirror_halted[r.task_sel] = 1'b0;
          end
          mirror_deadline[r.task_sel] =
              clamp_add(r.now_ms, {32'b0, mirror_period[r.task_sel]});
        end
        awaited_results.push_back(res);
      end
      pts_pkg::OP_QUERY: begin
        found = 1'b0;
        best = '0;
        best_id = '0;
        // earliest deadline among running tasks, lowest slot wins a tie
        for (int i = 0; i < mirror_count; i++) begin
          if (!mirror_halted[i] && (!found || mirror_deadline[i] < best)) begin
            found = 1'b1;
            best = mirror_deadline[i];
            best_id = 4'(i);
          end
        end
        if (!found) begin
          res.status = pts_pkg::ST_NONE;
          res.wait_ms = '1;
        end else begin
          res.task_id = best_id;
          if (best <= r.now_ms) begin
            res.wait_ms = '0;
          end else if (best - r.now_ms > 64'hFFFF_FFFF) begin
            res.wait_ms = '1;
          end else begin
            gap = best - r.now_ms;
            res.wait_ms = gap[31:0];
          end
        end
        awaited_results.push_back(res);
      end
      default: begin
        res.status = pts_pkg::ST_ERR;
        awaited_results.push_back(res);
      end
    endcase
  endfunction

  // Queue a request and track how many slots the table will hold by then.
  function automatic void queue_request(logic [2:0] op, logic [3:0] sel, logic [31:0] per,
                                        logic [2:0] mode, logic [63:0] now);
    sched_req_t r;
    r.op = op;
    r.task_sel = sel;
    r.period_ms = per;
    r.mode_flags = mode;
    r.now_ms = now;
    if (op == pts_pkg::OP_REG && per != 0 && per <= mirror_max_period &&
        planned_count < TASKS) begin
      planned_count++;
    end
    request_queue.push_back(r);
  endfunction

  // Mostly a forward-moving clock and valid slots, with a share of noise:
  // arbitrary times, bad slots, odd periods and the unknown op.
  function automatic void queue_random(int unsigned n);
    logic [2:0]  op;
    logic [3:0]  sel;
    logic [31:0] per;
    logic [63:0] now;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        op = pts_pkg::OP_REG;
      end else if (pick < 35) begin
        op = pts_pkg::OP_EXEC;
      end else if (pick < 45) begin
        op = pts_pkg::OP_HALT;
      end else if (pick < 57) begin
        op = pts_pkg::OP_CHG;
      end else if (pick < 70) begin
        op = pts_pkg::OP_RUN;
      end else if (pick < 78) begin
        op = pts_pkg::OP_CLR;
      end else if (pick < 96) begin
        op = pts_pkg::OP_QUERY;
      end else begin
        op = OP_UNKNOWN;
      end
      if (planned_count > 0 && $urandom_range(9) != 0) begin
        sel = 4'($urandom_range(planned_count - 1));
      end else begin
        sel = 4'($urandom_range(15));
      end
      case ($urandom_range(9))
        0: per = '0;
        1: per = $urandom;
        2: per = mirror_max_period;
        3: per = mirror_max_period + 1;
        default: per = $urandom_range(60, 1);
      endcase
      case ($urandom_range(49))
        0, 1: now = {$urandom, $urandom};
        2: now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(100);
        3: begin
          // long gap: pushes fast tasks past the run count ceiling
          wall_ms = wall_ms + $urandom_range(20000, 1000);
          now = wall_ms;
        end
        default: begin
          wall_ms = wall_ms + $urandom_range(40);
          now = wall_ms;
        end
      endcase
      queue_request(op, sel, per, 3'($urandom_range(7)), now);
    end
  endfunction

  // Hold the write until the port takes it, then mirror the new limit.
  task automatic set_max_period(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror_max_period = value;
  endtask

  // Stop feeding requests until every predicted result has come back.
  task automatic drain;
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Driver: present queued requests, predict each one at the edge it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        schedule_step(shown_req);
      end
      // the port is free when nothing is shown or the shown request just went in
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_req = request_queue.pop_front();
          in_valid      <= 1'b1;
          in_op         <= shown_req.op;
          in_task_sel   <= shown_req.task_sel;
          in_period_ms  <= shown_req.period_ms;
          in_mode_flags <= shown_req.mode_flags;
          in_now_ms     <= shown_req.now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction; stall at random.
  always @(posedge clk) begin
    sched_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: task_id %0d status %0d", out_task_id, out_status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("task_id", 64'(want.task_id), 64'(out_task_id));
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("fire_count", 64'(want.fire_count), 64'(out_fire_count));
          check_field("wait_ms", 64'(want.wait_ms), 64'(out_wait_ms));
          check_field("last", 64'(want.last), 64'(out_last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if traffic stops moving on every channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    mirror_max_period = '1;
    mirror_count = 0;
    planned_count = 0;
    wall_ms = 64'd3000;
    send_idle_pct = 34;
    recv_idle_pct = 70;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // widest limit first, then the directed table walk
    set_max_period(32'hFFFF_FFFF);
    @(negedge clk);
    queue_request(pts_pkg::OP_EXEC, 4'd0, 32'd0, 3'd0, 64'd0);      // empty table
    queue_request(pts_pkg::OP_QUERY, 4'd0, 32'd0, 3'd0, 64'd0);     // nothing to wait for
    queue_request(pts_pkg::OP_HALT, 4'd0, 32'd0, 3'd0, 64'd0);      // slot not yet filled
    queue_request(pts_pkg::OP_REG, 4'd0, 32'd0, 3'd0, 64'd5);       // zero period refused
    queue_request(OP_UNKNOWN, 4'hF, '1, 3'd7, '1);
    queue_request(pts_pkg::OP_REG, 4'd0, 32'd1, 3'd0, 64'd10);
    queue_request(pts_pkg::OP_REG, 4'd0, '1, 3'd5, 64'd10);         // skip, due now
    queue_request(pts_pkg::OP_REG, 4'd0, 32'd7, 3'd2, 64'd10);      // starts halted
    queue_request(pts_pkg::OP_EXEC, 4'd0, 32'd0, 3'd0, 64'd1000);   // run count clips at 255
    queue_request(pts_pkg::OP_CHG, 4'd0, 32'd3, 3'd0, 64'd1000);    // task still running
    queue_request(pts_pkg::OP_CHG, 4'd2, 32'd0, 3'd0, 64'd1000);    // keep old period
    queue_request(pts_pkg::OP_CHG, 4'd2, 32'd3, 3'd0, 64'd1000);
    queue_request(pts_pkg::OP_CHG, 4'hF, 32'd3, 3'd0, 64'd1000);    // slot out of range
    queue_request(pts_pkg::OP_QUERY, 4'd0, 32'd0, 3'd0, 64'd1000);
    queue_request(pts_pkg::OP_HALT, 4'd0, 32'd0, 3'd0, 64'd1000);
    queue_request(pts_pkg::OP_HALT, 4'd1, 32'd0, 3'd0, 64'd1000);
    queue_request(pts_pkg::OP_QUERY, 4'd0, 32'd0, 3'd0, 64'd1000);  // every task halted
    queue_request(pts_pkg::OP_EXEC, 4'd0, 32'd0, 3'd0, 64'd1010);   // halted tasks fire nothing
    // deadline clips
    queue_request(pts_pkg::OP_RUN, 4'd2, 32'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFD);
    queue_request(pts_pkg::OP_CLR, 4'd1, 32'd0, 3'd0, 64'd2000);
    queue_request(pts_pkg::OP_RUN, 4'd0, 32'd0, 3'd0, 64'd2000);
    queue_request(pts_pkg::OP_RUN, 4'd1, 32'd0, 3'd0, 64'd2000);
    queue_request(pts_pkg::OP_REG, 4'd0, 32'd100, 3'd4, 64'hFFFF_FFFF_FFFF_FFF5);
    queue_request(pts_pkg::OP_HALT, 4'd0, 32'd0, 3'd0, 64'd2000);
    queue_request(pts_pkg::OP_QUERY, 4'd0, 32'd0, 3'd0, 64'd5);     // wait clips at all ones
    queue_request(pts_pkg::OP_EXEC, 4'd0, 32'd0, 3'd0, '1);
    queue_random(120);
    drain();

    // narrowest limit, receiver now the faster side
    repeat (CFG_GAP) @(posedge clk);
    set_max_period(32'd1);
    send_idle_pct = 70;
    recv_idle_pct = 34;
    @(negedge clk);
    queue_random(100);
    drain();

    // mid-range limit, no idling on either side
    repeat (CFG_GAP) @(posedge clk);
    set_max_period($urandom_range(200, 2));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    queue_random(90);
    drain();

    // large random limit
    repeat (CFG_GAP) @(posedge clk);
    set_max_period($urandom | 32'h8000_0000);
    @(negedge clk);
    queue_random(90);
    drain();

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== periodic_task_scheduler.f =====
rtl/pts_pkg.sv
rtl/pts_alu.sv
rtl/periodic_task_scheduler.sv
rtl/pts_checker.sv
verif/tb_top.sv
